// ===== rtl/core/lfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpd_pkg
// Word types, control word layout, microprogram and constants shared by the
// line follower PID drive sequencer, datapath and top level.
// ----------------------------------------------------------------------------
package lfpd_pkg;

	localparam int SENSOR_W = 10;
	localparam int QUO_W    = 12;

	typedef struct packed {
		logic [SENSOR_W-1:0] sensor_far_left;
		logic [SENSOR_W-1:0] sensor_left;
		logic [SENSOR_W-1:0] sensor_center;
		logic [SENSOR_W-1:0] sensor_right;
		logic [SENSOR_W-1:0] sensor_far_right;
	} sensor_word_t;

	typedef struct packed {
		logic [7:0] left_drive;
		logic [7:0] right_drive;
		logic       line_lost;
	} drive_word_t;

	typedef struct packed {
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [7:0]  base_speed;
	} cfg_t;

	localparam logic [1:0] REG_GAIN_P     = 2'd0;
	localparam logic [1:0] REG_GAIN_I     = 2'd1;
	localparam logic [1:0] REG_GAIN_D     = 2'd2;
	localparam logic [1:0] REG_BASE_SPEED = 2'd3;

	localparam logic [15:0] GAIN_P_RST     = 16'd768;
	localparam logic [15:0] GAIN_I_RST     = 16'd0;
	localparam logic [15:0] GAIN_D_RST     = 16'd0;
	localparam logic [7:0]  BASE_SPEED_RST = 8'd75;

	localparam logic [QUO_W-1:0] POS_CENTER   = 12'd2000;
	localparam logic [9:0]       W_SCALE      = 10'd1000;
	localparam logic [7:0]       SPEED_OFFSET = 8'd30;
	localparam logic [23:0]      INTEG_MAX    = 24'h7FFFFF;
	localparam logic [23:0]      INTEG_MIN    = 24'h800000;

	localparam logic [3:0] OP_LOAD  = 4'd0;
	localparam logic [3:0] OP_WMUL  = 4'd1;
	localparam logic [3:0] OP_DIV   = 4'd2;
	localparam logic [3:0] OP_ERR   = 4'd3;
	localparam logic [3:0] OP_MUL_P = 4'd4;
	localparam logic [3:0] OP_MUL_I = 4'd5;
	localparam logic [3:0] OP_MUL_D = 4'd6;
	localparam logic [3:0] OP_ACC   = 4'd7;
	localparam logic [3:0] OP_MAG   = 4'd8;
	localparam logic [3:0] OP_EMIT  = 4'd9;
	localparam logic [3:0] OP_NOP   = 4'd10;

	localparam logic [2:0] C_NONE     = 3'd0;
	localparam logic [2:0] C_NO_IN    = 3'd1;
	localparam logic [2:0] C_LOST     = 3'd2;
	localparam logic [2:0] C_CNT_NZ   = 3'd3;
	localparam logic [2:0] C_OUT_FULL = 3'd4;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd2;
	localparam logic [3:0] ST_ERR  = 4'd3;
	localparam logic [3:0] ST_EMIT = 4'd9;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] cond;
		logic [3:0] target;
		logic       fin;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic lost;
		logic cnt_nz;
		logic out_full;
	} stat_t;

	function automatic ctl_t prog_rom(input logic [3:0] step);
		ctl_t w;
		case (step)
			4'd0: w = ctl_t'{OP_LOAD,  C_NO_IN,    ST_IDLE, 1'b0};
			4'd1: w = ctl_t'{OP_WMUL,  C_LOST,     ST_ERR,  1'b0};
			4'd2: w = ctl_t'{OP_DIV,   C_CNT_NZ,   ST_DIV,  1'b0};
			4'd3: w = ctl_t'{OP_ERR,   C_NONE,     ST_IDLE, 1'b0};
			4'd4: w = ctl_t'{OP_MUL_P, C_NONE,     ST_IDLE, 1'b0};
			4'd5: w = ctl_t'{OP_MUL_I, C_NONE,     ST_IDLE, 1'b0};
			4'd6: w = ctl_t'{OP_MUL_D, C_NONE,     ST_IDLE, 1'b0};
			4'd7: w = ctl_t'{OP_ACC,   C_NONE,     ST_IDLE, 1'b0};
			4'd8: w = ctl_t'{OP_MAG,   C_NONE,     ST_IDLE, 1'b0};
			4'd9: w = ctl_t'{OP_EMIT,  C_OUT_FULL, ST_EMIT, 1'b1};
			default: w = ctl_t'{OP_NOP, C_NONE,    ST_IDLE, 1'b1};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/lfpd_seq.sv =====
// ----------------------------------------------------------------------------
// lfpd_seq
// Microprogram sequencer: step counter, control word table and conditional
// jumps on datapath status.
// ----------------------------------------------------------------------------
module lfpd_seq import lfpd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl,
	output logic  idle
);

	logic [3:0] step_q;
	logic [3:0] step_nxt;
	logic       take;

	assign ctl  = prog_rom(step_q);
	assign idle = (step_q == ST_IDLE);

	always_comb begin
		case (ctl.cond)
			C_NONE:     take = 1'b0;
			C_NO_IN:    take = !stat.in_valid;
			C_LOST:     take = stat.lost;
			C_CNT_NZ:   take = stat.cnt_nz;
			C_OUT_FULL: take = stat.out_full;
			default:    take = 1'b0;
		endcase
	end

	always_comb begin
		if (take) begin
			step_nxt = ctl.target;
		end else if (ctl.fin) begin
			step_nxt = ST_IDLE;
		end else begin
			step_nxt = step_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

// ===== rtl/core/lfpd_dp.sv =====
// ----------------------------------------------------------------------------
// lfpd_dp
// Datapath: sensor sums, restoring divider, PID state, shared multiplier
// with accumulator, drive split and the output register.
// ----------------------------------------------------------------------------
module lfpd_dp import lfpd_pkg::*; #(
	parameter int SENSOR_BITS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  ctl_t         ctl,
	input  cfg_t         cfg,
	input  sensor_word_t sensors,
	input  logic         sensor_valid,
	input  logic         drive_stall,
	output stat_t        stat,
	output drive_word_t  drive,
	output logic         drive_valid
);

	localparam int KEEP = (SENSOR_BITS < SENSOR_W) ? SENSOR_BITS : SENSOR_W;
	localparam logic [SENSOR_W-1:0] SMASK = SENSOR_W'((32'd1 << KEEP) - 32'd1);

	logic [SENSOR_W-1:0] s0, s1, s2, s3, s4;
	logic [12:0] total_c;
	logic [13:0] w4_c;

	logic [12:0] total_q;
	logic [13:0] w4_q;
	logic        lost_q;

	logic [23:0]      rem_q;
	logic [23:0]      dsr_q;
	logic [QUO_W-1:0] quo_q;
	logic [3:0]       cnt_q;
	logic             ge;

	logic [QUO_W-1:0]   pos;
	logic signed [12:0] err_w;
	logic signed [12:0] deriv_w;
	logic signed [24:0] isum;
	logic signed [11:0] err_q;
	logic signed [11:0] prev_q;
	logic signed [12:0] deriv_q;
	logic signed [23:0] integ_q;

	logic signed [23:0] a_op;
	logic [15:0]        b_gain;
	logic signed [16:0] b_op;
	logic signed [40:0] prod_c;
	logic signed [40:0] prod_q;
	logic signed [41:0] acc_q;
	logic [41:0]        abs_c;
	logic               neg_q;
	logic [33:0]        mag_q;

	logic [7:0] maxv;
	logic [7:0] pdm;
	logic       emit_en;
	drive_word_t drive_q;
	logic        drive_valid_q;

	assign s0 = sensors.sensor_far_left & SMASK;
	assign s1 = sensors.sensor_left & SMASK;
	assign s2 = sensors.sensor_center & SMASK;
	assign s3 = sensors.sensor_right & SMASK;
	assign s4 = sensors.sensor_far_right & SMASK;

	assign total_c = 13'(s0) + 13'(s1) + 13'(s2) + 13'(s3) + 13'(s4);
	assign w4_c = {2'b00, s0, 2'b00} + {4'b0000, s1} + {3'b000, s1, 1'b0}
		+ {3'b000, s2, 1'b0} + {4'b0000, s3};

	assign ge = (rem_q >= dsr_q);

	assign pos     = lost_q ? POS_CENTER : quo_q;
	assign err_w   = $signed({1'b0, pos}) - $signed({1'b0, POS_CENTER});
	assign deriv_w = err_w - $signed({prev_q[11], prev_q});
	assign isum    = $signed({integ_q[23], integ_q}) + $signed({{12{err_w[12]}}, err_w});

	always_comb begin
		case (ctl.op)
			OP_MUL_I: begin
				a_op   = integ_q;
				b_gain = cfg.gain_i;
			end
			OP_MUL_D: begin
				a_op   = $signed({{11{deriv_q[12]}}, deriv_q});
				b_gain = cfg.gain_d;
			end
			default: begin
				a_op   = $signed({{12{err_q[11]}}, err_q});
				b_gain = cfg.gain_p;
			end
		endcase
	end

	assign b_op   = $signed({1'b0, b_gain});
	assign prod_c = a_op * b_op;
	assign abs_c  = acc_q[41] ? 42'(-acc_q) : 42'(acc_q);

	assign maxv = {1'b0, cfg.base_speed[7:1]} + SPEED_OFFSET;
	assign pdm  = (mag_q > {26'b0, maxv}) ? maxv : mag_q[7:0];

	assign stat.in_valid = sensor_valid;
	assign stat.lost     = lost_q;
	assign stat.cnt_nz   = (cnt_q != 4'd0);
	assign stat.out_full = drive_valid_q && drive_stall;

	assign emit_en = (ctl.op == OP_EMIT) && !stat.out_full;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				if (sensor_valid) begin
					total_q <= total_c;
					w4_q    <= w4_c;
					lost_q  <= (total_c == 13'd0);
				end
			end
			OP_WMUL: begin
				rem_q <= 24'({10'b0, w4_q} * {14'b0, W_SCALE});
				dsr_q <= {total_q, 11'b0};
				quo_q <= '0;
				cnt_q <= 4'(QUO_W - 1);
			end
			OP_DIV: begin
				if (ge) begin
					rem_q <= rem_q - dsr_q;
				end
				quo_q <= {quo_q[QUO_W-2:0], ge};
				dsr_q <= {1'b0, dsr_q[23:1]};
				cnt_q <= cnt_q - 4'd1;
			end
			OP_ERR: begin
				err_q   <= err_w[11:0];
				deriv_q <= deriv_w;
			end
			OP_MUL_P: begin
				prod_q <= prod_c;
				acc_q  <= '0;
			end
			OP_MUL_I, OP_MUL_D: begin
				prod_q <= prod_c;
				acc_q  <= acc_q + $signed({prod_q[40], prod_q});
			end
			OP_ACC: begin
				acc_q <= acc_q + $signed({prod_q[40], prod_q});
			end
			OP_MAG: begin
				neg_q <= acc_q[41];
				mag_q <= abs_c[41:8];
			end
			default: begin
			end
		endcase
		if (emit_en) begin
			drive_q.line_lost <= lost_q;
			if (neg_q) begin
				drive_q.left_drive  <= maxv - pdm;
				drive_q.right_drive <= maxv;
			end else begin
				drive_q.left_drive  <= maxv;
				drive_q.right_drive <= maxv - pdm;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
		end else if (ctl.op == OP_ERR) begin
			prev_q <= err_w[11:0];
			if (isum[24] != isum[23]) begin
				integ_q <= isum[24] ? $signed(INTEG_MIN) : $signed(INTEG_MAX);
			end else begin
				integ_q <= isum[23:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_valid_q <= 1'b0;
		end else if (emit_en) begin
			drive_valid_q <= 1'b1;
		end else if (!drive_stall) begin
			drive_valid_q <= 1'b0;
		end
	end

	assign drive       = drive_q;
	assign drive_valid = drive_valid_q;

endmodule

// ===== rtl/core/line_follow_pid_drive.sv =====
// ----------------------------------------------------------------------------
// line_follow_pid_drive
// PID steering for a line follower with a differential drive.
// ----------------------------------------------------------------------------
// Each sensor word carries five line-sensor readings and yields one drive
// word with the left and right motor commands and a line-lost flag.
// A sensor word is taken when sensor_valid is high and sensor_stall is low;
// a drive word is taken when drive_valid is high and drive_stall is low.
// The block holds sensor_stall high while it works on a word: the load, the
// 12 steps of the restoring divider (skipped when the sensor sum is zero),
// the error update, the passes through the shared multiplier, the accumulate
// and the magnitude; the result is then registered and the block returns to
// idle for the next word. A waiting drive word does not block the next
// sensor word; only the final step waits while a previous drive word is
// stalled. The user must write gains and base speed through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block itself
// does not enforce this. Reset loads the default gains, clears the previous
// error and the integral, and leaves no drive word pending.
// ----------------------------------------------------------------------------
module line_follow_pid_drive import lfpd_pkg::*; #(
	parameter int SENSOR_BITS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         sensor_valid,
	output logic         sensor_stall,
	input  sensor_word_t sensors,
	output logic         drive_valid,
	input  logic         drive_stall,
	output drive_word_t  drive,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	cfg_t  cfg_q;
	ctl_t  ctl;
	stat_t stat;
	logic  idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p     <= GAIN_P_RST;
			cfg_q.gain_i     <= GAIN_I_RST;
			cfg_q.gain_d     <= GAIN_D_RST;
			cfg_q.base_speed <= BASE_SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P:     cfg_q.gain_p     <= cfg_data;
				REG_GAIN_I:     cfg_q.gain_i     <= cfg_data;
				REG_GAIN_D:     cfg_q.gain_d     <= cfg_data;
				REG_BASE_SPEED: cfg_q.base_speed <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	lfpd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl),
		.idle   (idle)
	);

	lfpd_dp #(
		.SENSOR_BITS (SENSOR_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cfg          (cfg_q),
		.sensors      (sensors),
		.sensor_valid (sensor_valid),
		.drive_stall  (drive_stall),
		.stat         (stat),
		.drive        (drive),
		.drive_valid  (drive_valid)
	);

	assign sensor_stall = !idle;

endmodule
